>>> src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Types and constants shared by the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    // pipeline depth: input, r*v products, t, r*t products, rounding, output
    localparam int STAGES = 6;

    // rounding of 2*(r x t): add half an output lsb, keep bits from here up
    localparam int ROUND_SHIFT = 27;

    typedef logic signed [15:0] comp_t;   // input and output components
    typedef logic signed [16:0] r_t;      // signed quaternion vector part
    typedef logic signed [31:0] wv_t;     // w * v
    typedef logic signed [32:0] t_t;      // r * v products and t
    typedef logic signed [49:0] u_t;      // r * t products and r x t
    typedef logic signed [22:0] rnd_t;    // rounded 2*(r x t)
    typedef logic signed [23:0] sum_t;    // rounded term plus v

    localparam u_t   ROUND_HALF = 50'sh0000004000000;
    localparam sum_t OUT_MAX    = 24'sd32767;
    localparam sum_t OUT_MIN    = -24'sd32768;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [STAGES-1:0] load;    // stage register takes a new beat
        logic [STAGES-1:0] valid;   // stage register holds a live beat
    } ctrl_t;

endpackage

`default_nettype wire

>>> src/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a Q2.14 quaternion: t = r x v + w*v, then
// 2*(r x t) + v rounded to nearest and saturated to 16 bits.
// ----------------------------------------------------------------------------
//  port group   dir   handshake               payload
//  in_*         in    in_valid / in_ready     in_data   (qvr_pkg::in_t)
//  out_*        out   out_valid / out_ready   out_data  (qvr_pkg::out_t)
//  cfg_*        in    cfg_valid / cfg_ready   cfg_data  (sign_convention)
//
//  one beat per cycle sustained while out_ready stays high
//  six register stages: input, r*v and w*v products, t, r*t products,
//  rounding, add v and saturate; the 17x33 r*t multipliers set the depth
//  a stall at the output holds the last stage; empty stages further up keep
//  taking beats until the pipeline is full
//  reset clears all valid bits and sets sign_convention to 1 (r = -q)
//  cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire qvr_pkg::in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output qvr_pkg::out_t       out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data
);

    qvr_pkg::ctrl_t ctrl;

    logic sign_reg;

    // stage 0: input
    qvr_pkg::comp_t s0_w_reg;
    qvr_pkg::r_t    s0_r_reg [3];
    qvr_pkg::comp_t s0_v_reg [3];
    qvr_pkg::r_t    s0_r_next [3];

    // stage 1: cross product terms and w*v
    qvr_pkg::t_t    s1_a_reg  [3];
    qvr_pkg::t_t    s1_b_reg  [3];
    qvr_pkg::wv_t   s1_wv_reg [3];
    qvr_pkg::r_t    s1_r_reg  [3];
    qvr_pkg::comp_t s1_v_reg  [3];
    qvr_pkg::t_t    s1_a_next [3];
    qvr_pkg::t_t    s1_b_next [3];
    qvr_pkg::wv_t   s1_wv_next [3];

    // stage 2: t
    qvr_pkg::t_t    s2_t_reg [3];
    qvr_pkg::r_t    s2_r_reg [3];
    qvr_pkg::comp_t s2_v_reg [3];
    qvr_pkg::t_t    s2_t_next [3];

    // stage 3: r x t terms
    qvr_pkg::u_t    s3_a_reg [3];
    qvr_pkg::u_t    s3_b_reg [3];
    qvr_pkg::comp_t s3_v_reg [3];
    qvr_pkg::u_t    s3_a_next [3];
    qvr_pkg::u_t    s3_b_next [3];

    // stage 4: rounded 2*(r x t)
    qvr_pkg::rnd_t  s4_rnd_reg [3];
    qvr_pkg::comp_t s4_v_reg   [3];
    qvr_pkg::rnd_t  s4_rnd_next [3];

    // stage 5: output
    qvr_pkg::out_t  s5_out_reg;
    qvr_pkg::out_t  s5_out_next;

    qvr_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sign_reg <= cfg_data;
        end
    end

    // stage 0
    always_comb
    begin
        s0_r_next[0] = 17'(in_data.quat_x);
        s0_r_next[1] = 17'(in_data.quat_y);
        s0_r_next[2] = 17'(in_data.quat_z);
        if (sign_reg)
        begin
            s0_r_next[0] = -s0_r_next[0];
            s0_r_next[1] = -s0_r_next[1];
            s0_r_next[2] = -s0_r_next[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s0_w_reg    <= in_data.quat_w;
            s0_r_reg    <= s0_r_next;
            s0_v_reg[0] <= in_data.vec_x;
            s0_v_reg[1] <= in_data.vec_y;
            s0_v_reg[2] <= in_data.vec_z;
        end
    end

    // stage 1: t_j = a_j - b_j + w*v_j
    always_comb
    begin
        s1_a_next[0] = s0_r_reg[1] * s0_v_reg[2];
        s1_b_next[0] = s0_r_reg[2] * s0_v_reg[1];
        s1_a_next[1] = s0_r_reg[2] * s0_v_reg[0];
        s1_b_next[1] = s0_r_reg[0] * s0_v_reg[2];
        s1_a_next[2] = s0_r_reg[0] * s0_v_reg[1];
        s1_b_next[2] = s0_r_reg[1] * s0_v_reg[0];
        for (int j = 0; j < 3; j++)
        begin
            s1_wv_next[j] = s0_w_reg * s0_v_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            s1_a_reg  <= s1_a_next;
            s1_b_reg  <= s1_b_next;
            s1_wv_reg <= s1_wv_next;
            s1_r_reg  <= s0_r_reg;
            s1_v_reg  <= s0_v_reg;
        end
    end

    // stage 2: |t| stays below 3 * 2^30
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s2_t_next[j] = s1_a_reg[j] - s1_b_reg[j] + 33'(s1_wv_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            s2_t_reg <= s2_t_next;
            s2_r_reg <= s1_r_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    // stage 3: r x t products
    always_comb
    begin
        s3_a_next[0] = s2_r_reg[1] * s2_t_reg[2];
        s3_b_next[0] = s2_r_reg[2] * s2_t_reg[1];
        s3_a_next[1] = s2_r_reg[2] * s2_t_reg[0];
        s3_b_next[1] = s2_r_reg[0] * s2_t_reg[2];
        s3_a_next[2] = s2_r_reg[0] * s2_t_reg[1];
        s3_b_next[2] = s2_r_reg[1] * s2_t_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            s3_a_reg <= s3_a_next;
            s3_b_reg <= s3_b_next;
            s3_v_reg <= s2_v_reg;
        end
    end

    // stage 4: floor((u + 2^26) / 2^27), ties toward +inf
    always_comb
    begin
        qvr_pkg::u_t biased;
        for (int j = 0; j < 3; j++)
        begin
            biased = s3_a_reg[j] - s3_b_reg[j] + qvr_pkg::ROUND_HALF;
            s4_rnd_next[j] = biased[49:qvr_pkg::ROUND_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            s4_rnd_reg <= s4_rnd_next;
            s4_v_reg   <= s3_v_reg;
        end
    end

    // stage 5: add v and clip
    always_comb
    begin
        qvr_pkg::sum_t  sum;
        qvr_pkg::comp_t res [3];
        logic           sat;
        sat = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            sum = 24'(s4_rnd_reg[j]) + 24'(s4_v_reg[j]);
            if (sum > qvr_pkg::OUT_MAX)
            begin
                res[j] = 16'sh7fff;
                sat    = 1'b1;
            end
            else if (sum < qvr_pkg::OUT_MIN)
            begin
                res[j] = -16'sh8000;
                sat    = 1'b1;
            end
            else
            begin
                res[j] = sum[15:0];
            end
        end
        s5_out_next.rot_x     = res[0];
        s5_out_next.rot_y     = res[1];
        s5_out_next.rot_z     = res[2];
        s5_out_next.saturated = sat;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            s5_out_reg <= s5_out_next;
        end
    end

    assign out_data = s5_out_reg;

`ifndef SYNTHESIS
    // an accepted beat always lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ctrl.valid[0])
        else $error("accepted beat missing from input stage");

    // an empty input stage never refuses a beat
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.valid[0] |-> in_ready)
        else $error("input refused while input stage empty");

    // saturation flag implies some component sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.rot_x == 16'sh7fff || out_data.rot_x == -16'sh8000 ||
            out_data.rot_y == 16'sh7fff || out_data.rot_y == -16'sh8000 ||
            out_data.rot_z == 16'sh7fff || out_data.rot_z == -16'sh8000)
        else $error("saturated set with no clipped component");

    // a stalled output beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    // configuration write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> sign_reg == $past(cfg_data))
        else $error("sign convention write lost");
`endif

endmodule

`default_nettype wire

>>> src/qvr_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// qvr_pipe_ctrl
// Valid and load control for the rotation pipeline; bubbles collapse under a
// stall so a stage takes a beat whenever it is empty or its successor moves.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_pipe_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output qvr_pkg::ctrl_t     ctrl
);

    logic [qvr_pkg::STAGES-1:0] valid_reg;
    logic [qvr_pkg::STAGES-1:0] valid_next;
    logic [qvr_pkg::STAGES:0]   ready;

    always_comb
    begin
        ready[qvr_pkg::STAGES] = out_ready;
        for (int k = qvr_pkg::STAGES - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < qvr_pkg::STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = ready[0];
    assign out_valid  = valid_reg[qvr_pkg::STAGES-1];
    assign ctrl.load  = ready[qvr_pkg::STAGES-1:0];
    assign ctrl.valid = valid_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_vector_rotate. A queue-fed driver pushes
// rotation beats in random bursts, while the output side stalls on its own
// pattern. Every accepted input beat is run through a bit-exact rotation
// predictor, and every output beat is checked against the oldest prediction.
// The sign convention is switched between phases while the pipe is empty.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 212;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    qvr_pkg::in_t   in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    qvr_pkg::out_t  out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic           cfg_data  = 1'b0;

    qvr_pkg::in_t   pending_items [$];
    qvr_pkg::out_t  expected_rot [$];
    logic  sign_model = 1'b1;   // reset value: r = -q
    int    error_count = 0;
    int    out_count   = 0;
    int    burst_left  = 1;
    int    gap_left    = 0;
    int    hold_left   = 0;
    int    idle_cycles = 0;

    quaternion_vector_rotate dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // exact rotation: t = r x v + w*v, out = round(2*(r x t)) + v, saturated
    function automatic qvr_pkg::out_t predict_rotation(qvr_pkg::in_t item, logic neg_sign);
        longint w;
        longint r [3];
        longint v [3];
        longint t [3];
        longint u [3];
        longint y;
        qvr_pkg::comp_t rot [3];
        logic   sat;
        w    = longint'(item.quat_w);
        r[0] = longint'(item.quat_x);
        r[1] = longint'(item.quat_y);
        r[2] = longint'(item.quat_z);
        v[0] = longint'(item.vec_x);
        v[1] = longint'(item.vec_y);
        v[2] = longint'(item.vec_z);
        sat  = 1'b0;
        if (neg_sign)
        begin
            for (int j = 0; j < 3; j++)
                r[j] = -r[j];
        end
        t[0] = r[1] * v[2] - r[2] * v[1] + w * v[0];
        t[1] = r[2] * v[0] - r[0] * v[2] + w * v[1];
        t[2] = r[0] * v[1] - r[1] * v[0] + w * v[2];
        u[0] = r[1] * t[2] - r[2] * t[1];
        u[1] = r[2] * t[0] - r[0] * t[2];
        u[2] = r[0] * t[1] - r[1] * t[0];
        for (int j = 0; j < 3; j++)
        begin
            // u is in 2^-28 units; doubling and rounding ties up in one shift
            y = ((u[j] + (64'sd1 <<< (qvr_pkg::ROUND_SHIFT - 1)))
                 >>> qvr_pkg::ROUND_SHIFT) + v[j];
            if (y > 32767)
            begin
                y   = 32767;
                sat = 1'b1;
            end
            else if (y < -32768)
            begin
                y   = -32768;
                sat = 1'b1;
            end
            rot[j] = qvr_pkg::comp_t'(y);
        end
        return '{rot[0], rot[1], rot[2], sat};
    endfunction

    function automatic qvr_pkg::in_t make_item(int w, int x, int y, int z,
                                               int vx, int vy, int vz);
        return '{qvr_pkg::comp_t'(w), qvr_pkg::comp_t'(x), qvr_pkg::comp_t'(y),
                 qvr_pkg::comp_t'(z), qvr_pkg::comp_t'(vx), qvr_pkg::comp_t'(vy),
                 qvr_pkg::comp_t'(vz)};
    endfunction

    function automatic qvr_pkg::comp_t rand_quat_comp(int mode);
        int pick;
        case (mode)
            0, 1, 2, 3, 4, 5: return qvr_pkg::comp_t'($urandom_range(0, 32768) - 16384);
            6, 7:             return qvr_pkg::comp_t'($urandom);
            8:                return qvr_pkg::comp_t'($urandom_range(0, 128) - 64);
            default:
            begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       return qvr_pkg::comp_t'(16384);
                    1:       return qvr_pkg::comp_t'(-16384);
                    2:       return qvr_pkg::comp_t'(0);
                    3:       return qvr_pkg::comp_t'(-32768);
                    4:       return qvr_pkg::comp_t'(32767);
                    default: return qvr_pkg::comp_t'(11585);
                endcase
            end
        endcase
    endfunction

    function automatic qvr_pkg::comp_t rand_vec_comp(int mode);
        case (mode)
            0, 1, 2, 3, 4, 5, 6: return qvr_pkg::comp_t'($urandom);
            7:                   return qvr_pkg::comp_t'($urandom_range(0, 512) - 256);
            default:             return ($urandom_range(0, 1) == 1)
                                        ? qvr_pkg::comp_t'(32767)
                                        : qvr_pkg::comp_t'(-32768);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t, output beat %0d: %s", $realtime, out_count, msg);
    endtask

    task automatic load_directed();
        // identity, negated identity, zero and scaled-down quaternions
        pending_items.push_back(make_item(16384, 0, 0, 0, 100, -200, 300));
        pending_items.push_back(make_item(16384, 0, 0, 0, 32767, -32768, 0));
        pending_items.push_back(make_item(-16384, 0, 0, 0, -32768, 32767, -1));
        pending_items.push_back(make_item(0, 0, 0, 0, 1, 2, 3));
        pending_items.push_back(make_item(8192, 0, 0, 0, -32768, -32768, 32767));
        // quarter turn about z, half turn about x and about z
        pending_items.push_back(make_item(11585, 0, 0, 11585, 1000, 0, 0));
        pending_items.push_back(make_item(0, 16384, 0, 0, 0, 1000, -1000));
        pending_items.push_back(make_item(0, 0, 0, 16384, -32768, 32767, 1));
        // non-unit quaternions driving the sum into both rails
        pending_items.push_back(make_item(16384, 16384, 16384, 16384, 32767, 32767, 32767));
        pending_items.push_back(make_item(-16384, -16384, -16384, -16384,
                                          -32768, -32768, -32768));
        // full 16-bit patterns outside [-1, 1]
        pending_items.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        pending_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768));
        pending_items.push_back(make_item(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_rot.size() != 0);
        repeat (qvr_pkg::STAGES + 2) @(posedge clk);
    endtask

    task automatic write_sign(input logic value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sign_model = value;
        cfg_valid <= 1'b0;
    endtask

    // input driver: bursts of random length, random gaps in between
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_rot.push_back(predict_rotation(in_data, sign_model));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and stall pattern
    always @(posedge clk)
    begin : monitor
        qvr_pkg::out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rot.size() == 0)
                    report_mismatch("output beat with nothing expected");
                else
                begin
                    want = expected_rot.pop_front();
                    if (out_data.rot_x !== want.rot_x)
                        report_mismatch($sformatf("rot_x got %0d want %0d",
                                                  out_data.rot_x, want.rot_x));
                    if (out_data.rot_y !== want.rot_y)
                        report_mismatch($sformatf("rot_y got %0d want %0d",
                                                  out_data.rot_y, want.rot_y));
                    if (out_data.rot_z !== want.rot_z)
                        report_mismatch($sformatf("rot_z got %0d want %0d",
                                                  out_data.rot_z, want.rot_z));
                    if (out_data.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %b want %b",
                                                  out_data.saturated, want.saturated));
                end
                out_count++;
            end
            if (hold_left > 0)
                hold_left = hold_left - 1;
            else if (out_ready)
            begin
                out_ready <= 1'b0;
                hold_left = $urandom_range(0, 7);
            end
            else
            begin
                out_ready <= 1'b1;
                hold_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(0, 20);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int qmode;
        int vmode;
        qvr_pkg::in_t item;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed set under the reset convention, then under the other one
        load_directed();
        wait_drain();
        write_sign(1'b0);
        load_directed();

        for (int phase_idx = 0; phase_idx < RAND_PHASES; phase_idx++)
        begin
            wait_drain();
            if (phase_idx == 0)
                write_sign(1'b1);
            else if (phase_idx == 1)
                write_sign(1'b0);
            else
                write_sign(logic'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                qmode = $urandom_range(0, 9);
                vmode = $urandom_range(0, 8);
                item.quat_w = rand_quat_comp(qmode);
                item.quat_x = rand_quat_comp(qmode);
                item.quat_y = rand_quat_comp(qmode);
                item.quat_z = rand_quat_comp(qmode);
                item.vec_x  = rand_vec_comp(vmode);
                item.vec_y  = rand_vec_comp(vmode);
                item.vec_z  = rand_vec_comp(vmode);
                pending_items.push_back(item);
            end
        end

        wait_drain();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
